// ===== src/sto_pkg.sv =====
// Shared types, constants and table functions for the sine tone oscillator.
// No dependencies; every other file of the block but sto_fifo imports this package.
package sto_pkg;

   // Field widths fixed by the register map and the sample format.
   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 15;
   localparam int VOL_W      = 16;
   localparam int STEP_W     = 32;
   localparam int LEN_W      = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_MODE         = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CYCLE_LENGTH = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VOLUME       = 8'd3;

   // Limits and reset values of the registers.
   localparam logic [LEN_W-1:0] MIN_CYCLE   = 16'd10;
   localparam logic [VOL_W-1:0] FULL_VOLUME = 16'd32768;

   // Constants of the quarter-wave table generator (Q62 angle arithmetic).
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
   localparam logic [63:0] FULL_SCALE  = 64'd32767;
   localparam int TAYLOR_TERMS = 13;
   // Denominators n*(n-1) for the odd Taylor terms n = 3, 5, ... 27.
   localparam logic [63:0] TAYLOR_DEN [TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
      64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
   };

   // Per-command flags passed from the front end to the back end.
   typedef struct packed {
      logic neg;
      logic tone_last;
      logic cycle_last;
   } sto_flags_type;

   // One finished result as it sits in the result queue.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       tone_last;
      logic                       cycle_last;
   } sto_result_type;

   // Q62 product with truncation: (a * b) >> 62.
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // Quarter-wave entry j of a table whose quarter holds 2^qbits steps.
   // Used only at elaboration to build the constant sine table.
   function automatic logic [MAG_W-1:0] quarter_value(input int unsigned j,
                                                      input int unsigned qbits);
      logic [63:0] frac;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] r;
      logic [63:0] v;
      frac = HALF_PI_Q62 & ((64'd1 << qbits) - 64'd1);
      x    = (HALF_PI_Q62 >> qbits) * 64'(j) + ((frac * 64'(j)) >> qbits);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int i = 0; i < TAYLOR_TERMS; i++) begin
         term = mul_q62(term, x2) / TAYLOR_DEN[i];
         if ((i % 2) == 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      r = FULL_SCALE * (sum >> 32) + ((FULL_SCALE * (sum & 64'hFFFF_FFFF)) >> 32);
      v = (r + (64'd1 << 29)) >> 30;
      if (v > FULL_SCALE) begin
         v = FULL_SCALE;
      end
      return v[MAG_W-1:0];
   endfunction

endpackage

// ===== src/sto_fifo.sv =====
// Small synchronous FIFO built from flip-flops, used for the command and
// result queues. Depends on nothing but its parameters.
module sto_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; only entries that were written are read.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/sto_front.sv =====
// Front end: configuration registers, phase accumulator and cycle counter.
// Classifies each tick into a quarter-table index and flags. Uses sto_pkg.
module sto_front import sto_pkg::*; #(
   parameter int PHASE_BITS = 32,
   parameter int TABLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_end_of_tone,
   input  logic                   cmd_full,
   output logic                   cmd_push,
   output logic [TABLE_BITS-2:0]  cmd_qidx,
   output sto_flags_type          cmd_flags,
   output logic [VOL_W-1:0]       volume
);

   localparam logic [TABLE_BITS-1:0] QUARTER_K = TABLE_BITS'(1 << (TABLE_BITS - 2));
   localparam logic [TABLE_BITS-1:0] HALF_K    = TABLE_BITS'(1 << (TABLE_BITS - 1));
   localparam logic [TABLE_BITS-1:0] THREE_Q_K = HALF_K + QUARTER_K;

   logic                  mode_ff;
   logic [STEP_W-1:0]     phase_step_ff;
   logic [LEN_W-1:0]      cycle_length_ff;
   logic [VOL_W-1:0]      volume_ff;
   logic [PHASE_BITS-1:0] phase_acc_ff, phase_acc_in;
   logic [LEN_W-1:0]      cycle_count_ff, cycle_count_in;
   logic                  accept;
   logic                  wrap;
   logic [LEN_W:0]        count_plus;
   logic [TABLE_BITS-1:0] k;
   logic [TABLE_BITS-1:0] idx_full;
   logic                  neg;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;
   assign volume    = volume_ff;

   // Register writes; limits are applied as the value is stored.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= 1'b0;
         phase_step_ff   <= '0;
         cycle_length_ff <= MIN_CYCLE;
         volume_ff       <= FULL_VOLUME;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MODE: begin
               mode_ff <= csr_data[0];
            end
            REG_PHASE_STEP: begin
               phase_step_ff <= csr_data[STEP_W-1:0];
            end
            REG_CYCLE_LENGTH: begin
               cycle_length_ff <= (csr_data[LEN_W-1:0] < MIN_CYCLE) ?
                                  MIN_CYCLE : csr_data[LEN_W-1:0];
            end
            REG_VOLUME: begin
               volume_ff <= (csr_data[VOL_W-1:0] > FULL_VOLUME) ?
                            FULL_VOLUME : csr_data[VOL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Fold the full-wave index onto the stored quarter wave.
   assign k = phase_acc_ff[PHASE_BITS-1 -: TABLE_BITS];
   always_comb begin
      priority if (k <= QUARTER_K) begin
         idx_full = k;
         neg      = 1'b0;
      end else if (k <= HALF_K) begin
         idx_full = HALF_K - k;
         neg      = 1'b0;
      end else if (k <= THREE_Q_K) begin
         idx_full = k - HALF_K;
         neg      = 1'b1;
      end else begin
         idx_full = '0 - k;
         neg      = 1'b1;
      end
   end

   // Cycle counter and phase update for the accepted tick.
   assign count_plus = {1'b0, cycle_count_ff} + (LEN_W + 1)'(1);
   assign wrap       = mode_ff && (count_plus >= {1'b0, cycle_length_ff});

   always_comb begin
      if (!mode_ff || wrap || req_end_of_tone) begin
         cycle_count_in = '0;
      end else begin
         cycle_count_in = count_plus[LEN_W-1:0];
      end
      if (req_end_of_tone || wrap) begin
         phase_acc_in = '0;
      end else begin
         phase_acc_in = phase_acc_ff + PHASE_BITS'(phase_step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff   <= '0;
         cycle_count_ff <= '0;
      end else if (accept) begin
         phase_acc_ff   <= phase_acc_in;
         cycle_count_ff <= cycle_count_in;
      end
   end

   // Command toward the back end.
   assign cmd_push             = accept;
   assign cmd_qidx             = idx_full[TABLE_BITS-2:0];
   assign cmd_flags.neg        = neg;
   assign cmd_flags.tone_last  = req_end_of_tone;
   assign cmd_flags.cycle_last = wrap;

   // A tone end always restarts phase and count.
   a_tone_end_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_tone |=> phase_acc_ff == '0 && cycle_count_ff == '0)
      else $error("phase or count not cleared after tone end");

   // In free-running mode the cycle counter stays at zero.
   a_free_mode_count: assert property (@(posedge clock) disable iff (reset)
      accept && !mode_ff |=> cycle_count_ff == '0)
      else $error("cycle count moved in free-running mode");

endmodule

// ===== src/sto_sine_rom.sv =====
// Quarter-wave sine table with a registered read port. The entries are
// constants built at elaboration by the generator function in sto_pkg.
module sto_sine_rom import sto_pkg::*; #(
   parameter int TABLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [TABLE_BITS-2:0] addr,
   output logic [MAG_W-1:0]      data
);

   localparam int QBITS = TABLE_BITS - 2;
   localparam int QLEN  = 1 << QBITS;

   logic [MAG_W-1:0] rom_tab [QLEN + 1];
   logic [MAG_W-1:0] data_ff;

   // Quarter wave plus its end point, indexes 0 to a quarter period.
   for (genvar g = 0; g <= QLEN; g++) begin : g_entry
      localparam logic [MAG_W-1:0] ENTRY = quarter_value(g, QBITS);
      assign rom_tab[g] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= rom_tab[addr];
      end
   end

   assign data = data_ff;

endmodule

// ===== src/sto_back.sv =====
// Back end: table lookup and volume scaling, with credit flow control
// toward the result queue. Uses sto_pkg and sto_sine_rom.
module sto_back import sto_pkg::*; #(
   parameter int TABLE_BITS = 10,
   parameter int OUT_DEPTH  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   input  logic [TABLE_BITS-2:0] cmd_qidx,
   input  sto_flags_type         cmd_flags,
   input  logic [VOL_W-1:0]      volume,
   output logic                  res_push,
   output sto_result_type        res_data,
   input  logic                  res_taken
);

   localparam int CW = $clog2(OUT_DEPTH + 1);

   logic                    issue;
   logic [CW-1:0]           outstanding_ff, outstanding_in;
   logic                    s1_valid_ff;
   sto_flags_type           s1_flags_ff;
   logic [MAG_W-1:0]        s1_mag;
   logic [MAG_W+VOL_W-1:0]  prod;
   logic [SAMPLE_W-1:0]     scaled;

   // Issue only while the result queue has room for everything in flight.
   assign issue   = !cmd_empty && (outstanding_ff < CW'(OUT_DEPTH));
   assign cmd_pop = issue;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (issue && !res_taken) begin
         outstanding_in = outstanding_ff + CW'(1);
      end else if (res_taken && !issue) begin
         outstanding_in = outstanding_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         outstanding_ff <= outstanding_in;
         s1_valid_ff    <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_flags_ff <= cmd_flags;
      end
   end

   // Stage one: registered table read.
   sto_sine_rom #(
      .TABLE_BITS(TABLE_BITS)
   ) u_rom (
      .clock(clock),
      .rd_en(issue),
      .addr (cmd_qidx),
      .data (s1_mag)
   );

   // Stage two: scale by volume, truncate, then restore the sign.
   assign prod   = (MAG_W + VOL_W)'(s1_mag) * (MAG_W + VOL_W)'(volume);
   assign scaled = prod[MAG_W+VOL_W-1 -: SAMPLE_W];

   assign res_push            = s1_valid_ff;
   assign res_data.sample     = s1_flags_ff.neg ? ('0 - scaled) : scaled;
   assign res_data.tone_last  = s1_flags_ff.tone_last;
   assign res_data.cycle_last = s1_flags_ff.cycle_last;

   // Credits never exceed the result queue depth.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= CW'(OUT_DEPTH))
      else $error("more results in flight than queue slots");

   // A result can only be taken while one is outstanding.
   a_credit_underflow: assert property (@(posedge clock) disable iff (reset)
      res_taken |-> outstanding_ff != '0)
      else $error("result taken with no outstanding credit");

   // Every issued command reaches the result queue in the next cycle.
   a_issue_lands: assert property (@(posedge clock) disable iff (reset)
      issue |=> res_push)
      else $error("issued command did not produce a result");

endmodule

// ===== src/sine_tone_oscillator_top.sv =====
// Top level of the sine tone oscillator: front end, command queue, back end
// and result queue. Uses sto_pkg, sto_fifo, sto_front and sto_back.
//
// Table-based numerically controlled oscillator. Each tick pushed on req_
// yields one signed 16-bit sample on rsp_, in order, one tick per clock
// cycle sustained while the queues have room. The front end updates the
// phase accumulator and cycle counter in the cycle a tick is accepted, so
// this add-and-select loop sets the rate of one tick per cycle; the back
// end then reads the registered sine table and scales by volume. A full
// result queue backs up into the command queue, and req_full rises when
// the command queue is full. OUT_DEPTH must be at least 3 to keep the
// back end at full rate. The user must write registers through csr_ only
// while the block is idle, which the block itself does not enforce; volume
// above 1.0 and cycle lengths below ten are clamped on write.
module sine_tone_oscillator_top import sto_pkg::*; #(
   parameter int PHASE_BITS = 32,
   parameter int TABLE_BITS = 10,
   parameter int CMD_DEPTH  = 4,
   parameter int OUT_DEPTH  = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic                       req_end_of_tone,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_tone_last,
   output logic                       rsp_cycle_last
);

   localparam int QW   = TABLE_BITS - 1;
   localparam int CMDW = QW + $bits(sto_flags_type);

   logic                  cmd_full;
   logic                  cmd_empty;
   logic                  cmd_push;
   logic                  cmd_pop;
   logic [TABLE_BITS-2:0] front_qidx;
   sto_flags_type         front_flags;
   logic [CMDW-1:0]       cmd_wdata;
   logic [CMDW-1:0]       cmd_rdata;
   logic [TABLE_BITS-2:0] back_qidx;
   sto_flags_type         back_flags;
   logic [VOL_W-1:0]      volume;
   logic                  res_push;
   sto_result_type        res_wdata;
   sto_result_type        res_rdata;
   logic                  res_full;
   logic                  res_taken;

   // Front end: registers, phase and classification.
   sto_front #(
      .PHASE_BITS(PHASE_BITS),
      .TABLE_BITS(TABLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_end_of_tone(req_end_of_tone),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd_qidx       (front_qidx),
      .cmd_flags      (front_flags),
      .volume         (volume)
   );

   // Command queue between the two halves.
   assign cmd_wdata = {front_qidx, front_flags};

   sto_fifo #(
      .WIDTH(CMDW),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock(clock),
      .reset(reset),
      .push (cmd_push),
      .wdata(cmd_wdata),
      .full (cmd_full),
      .pop  (cmd_pop),
      .rdata(cmd_rdata),
      .empty(cmd_empty)
   );

   assign back_qidx  = cmd_rdata[CMDW-1 -: QW];
   assign back_flags = sto_flags_type'(cmd_rdata[$bits(sto_flags_type)-1:0]);

   // Back end: table lookup and scaling.
   sto_back #(
      .TABLE_BITS(TABLE_BITS),
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .cmd_qidx (back_qidx),
      .cmd_flags(back_flags),
      .volume   (volume),
      .res_push (res_push),
      .res_data (res_wdata),
      .res_taken(res_taken)
   );

   // Result queue toward the consumer.
   sto_fifo #(
      .WIDTH($bits(sto_result_type)),
      .DEPTH(OUT_DEPTH)
   ) u_res_fifo (
      .clock(clock),
      .reset(reset),
      .push (res_push),
      .wdata(res_wdata),
      .full (res_full),
      .pop  (rsp_pop),
      .rdata(res_rdata),
      .empty(rsp_empty)
   );

   assign res_taken      = rsp_pop && !rsp_empty;
   assign rsp_sample     = res_rdata.sample;
   assign rsp_tone_last  = res_rdata.tone_last;
   assign rsp_cycle_last = res_rdata.cycle_last;

   // Credit control must never let the back end write a full result queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_full |-> !res_push || res_taken)
      else $error("result written into a full queue");

endmodule
